@@ hdl/printer_line_text_formatter_macros.svh @@
// assertion helpers for the top-level file, which checks its own logic
`ifndef PRINTER_LINE_TEXT_FORMATTER_MACROS_SVH
`define PRINTER_LINE_TEXT_FORMATTER_MACROS_SVH

// same-cycle implication
`define PLTF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pltf check failed");

// next-cycle implication
`define PLTF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pltf check failed");

`endif

@@ hdl/pltf_pkg.sv @@
package pltf_pkg;

   localparam int DEF_MAX_LINE      = 255;
   localparam int DEF_LIMIT_CMD     = 100;
   localparam int DEF_LIMIT_GENERIC = 102;
   localparam int DEF_QUEUE_DEPTH   = 4;

   localparam int BODY_SLOTS = 4;
   localparam int SLOTS      = 6;

   // item kinds
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_CHAR   = 1'b1;

   // printer status bits
   localparam int ST_LC_BIT = 0;
   localparam int ST_DW_BIT = 2;
   localparam int ST_RJ_BIT = 3;
   localparam int ST_EB_BIT = 4;

   // printer bytes
   localparam logic [7:0] BYTE_ESC       = 8'h1b;
   localparam logic [7:0] BYTE_EIGHT_BIT = 8'h7c;
   localparam logic [7:0] BYTE_STD_SET   = 8'hfc;
   localparam logic [7:0] BYTE_JUSTIFY   = 8'he0;
   localparam logic [7:0] BYTE_FORMAT    = 8'hd0;
   localparam logic [7:0] BYTE_CR        = 8'h0d;
   localparam logic [7:0] BYTE_LF        = 8'h0a;
   localparam logic [7:0] BYTE_NONE      = 8'h00;

   // result slots of one descriptor
   localparam logic [2:0] SLOT_ESC  = 3'd0;
   localparam logic [2:0] SLOT_SET  = 3'd1;
   localparam logic [2:0] SLOT_JUST = 3'd2;
   localparam logic [2:0] SLOT_FMT  = 3'd3;
   localparam logic [2:0] SLOT_CR   = 3'd4;
   localparam logic [2:0] SLOT_LF   = 3'd5;

   // csr address decode
   localparam logic CSR_IDX_MODE = 1'b0;

   // character translation for the command-set printer
   localparam logic [7:0] XLAT_TABLE [0:127] = '{
      8'hAF, 8'h01, 8'h3f, 8'h53, 8'h1f, 8'h7e, 8'h3e, 8'h7b,
      8'h3f, 8'h3f, 8'h0a, 8'h3f, 8'h1d, 8'h0d, 8'h07, 8'h7d,
      8'h03, 8'h0c, 8'h1e, 8'h3f, 8'h13, 8'h3f, 8'h16, 8'h7c,
      8'h45, 8'h1b, 8'h3f, 8'h3f, 8'h17, 8'h1a, 8'h1e, 8'h3f,
      8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27,
      8'h28, 8'h29, 8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
      8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
      8'h38, 8'h39, 8'h3a, 8'h3b, 8'h3c, 8'h3d, 8'h3e, 8'h3f,
      8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47,
      8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c, 8'h4d, 8'h4e, 8'h4f,
      8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57,
      8'h58, 8'h59, 8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f,
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67,
      8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f,
      8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77,
      8'h78, 8'h79, 8'h7a, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'h7f
   };

   // one classified item: up to four body bytes, then cr/lf or a bare marker
   typedef struct packed {
      logic [BODY_SLOTS-1:0][7:0] body;
      logic [SLOTS-1:0]           mask;
      logic                       bare;
   } pltf_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pltf_qstat_type;

endpackage

@@ hdl/pltf_if.sv @@
interface pltf_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_code;
   logic [7:0] line_length;
   logic       want_lowercase;
   logic       want_double_wide;
   logic       want_right_justify;
   logic [7:0] printer_status;

   modport source (
      output valid, kind, char_code, line_length, want_lowercase,
             want_double_wide, want_right_justify, printer_status,
      input  ready
   );
   modport sink (
      input  valid, kind, char_code, line_length, want_lowercase,
             want_double_wide, want_right_justify, printer_status,
      output ready
   );
endinterface

interface pltf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_present;
   logic       line_end;

   modport source (
      output valid, out_byte, byte_present, line_end,
      input  ready
   );
   modport sink (
      input  valid, out_byte, byte_present, line_end,
      output ready
   );
endinterface

@@ hdl/pltf_front.sv @@
module pltf_front #(
   parameter int MAX_LINE      = pltf_pkg::DEF_MAX_LINE,
   parameter int LIMIT_CMD     = pltf_pkg::DEF_LIMIT_CMD,
   parameter int LIMIT_GENERIC = pltf_pkg::DEF_LIMIT_GENERIC
) (
   input  logic                    clock,
   input  logic                    reset,
   pltf_req_if.sink                req,
   input  logic                    mode_cmd,
   input  pltf_pkg::pltf_qstat_type qstat,
   output logic                    push,
   output pltf_pkg::pltf_desc_type push_desc
);
   import pltf_pkg::*;

   logic [7:0] chars_left_ff, chars_left_in;
   logic [6:0] bytes_sent_ff, bytes_sent_in;
   logic       eight_bit_on_ff, eight_bit_on_in;
   logic       line_open_ff, line_open_in;

   logic       accept;
   logic [7:0] len_sat;
   logic [7:0] xlat_byte;

   assign req.ready = !qstat.full;
   assign accept    = req.valid && req.ready;
   assign len_sat   = (req.line_length > 8'(MAX_LINE)) ? 8'(MAX_LINE) : req.line_length;
   assign xlat_byte = XLAT_TABLE[req.char_code[6:0]];

   always_comb begin
      logic [6:0] bs;
      logic       finish;
      chars_left_in   = chars_left_ff;
      bytes_sent_in   = bytes_sent_ff;
      eight_bit_on_in = eight_bit_on_ff;
      line_open_in    = line_open_ff;
      push_desc       = '0;
      finish          = 1'b0;
      bs              = bytes_sent_ff;
      if (accept) begin
         if (req.kind == KIND_HEADER) begin
            bs              = '0;
            eight_bit_on_in = 1'b0;
            line_open_in    = 1'b1;
            chars_left_in   = len_sat;
            if (mode_cmd) begin
               if (!req.printer_status[ST_EB_BIT]) begin
                  push_desc.mask[SLOT_ESC] = 1'b1;
                  push_desc.mask[SLOT_SET] = 1'b1;
                  push_desc.body[SLOT_ESC[1:0]] = BYTE_ESC;
                  push_desc.body[SLOT_SET[1:0]] = BYTE_EIGHT_BIT;
                  bs = bs + 7'd2;
               end
               eight_bit_on_in = 1'b1;
               if (req.printer_status[ST_RJ_BIT] != req.want_right_justify) begin
                  push_desc.mask[SLOT_JUST] = 1'b1;
                  push_desc.body[SLOT_JUST[1:0]] =
                     BYTE_JUSTIFY | {4'b0, req.want_right_justify, 3'b0};
                  bs = bs + 7'd1;
               end
               if ((req.printer_status[ST_LC_BIT] != req.want_lowercase) ||
                   (req.printer_status[ST_DW_BIT] != req.want_double_wide)) begin
                  push_desc.mask[SLOT_FMT] = 1'b1;
                  push_desc.body[SLOT_FMT[1:0]] =
                     BYTE_FORMAT | {5'b0, req.want_double_wide, 1'b0, req.want_lowercase};
                  bs = bs + 7'd1;
               end
            end
            finish = (len_sat == 8'd0);
         end else if (line_open_ff && chars_left_ff != 8'd0) begin
            if (mode_cmd) begin
               if (bytes_sent_ff < 7'(LIMIT_CMD)) begin
                  // one-time switch back to the standard set
                  if (xlat_byte[7] && eight_bit_on_ff) begin
                     push_desc.mask[SLOT_ESC] = 1'b1;
                     push_desc.body[SLOT_ESC[1:0]] = BYTE_STD_SET;
                     eight_bit_on_in = 1'b0;
                     bs = bs + 7'd1;
                  end
                  push_desc.mask[SLOT_SET] = 1'b1;
                  push_desc.body[SLOT_SET[1:0]] = {1'b0, xlat_byte[6:0]};
                  bs = bs + 7'd1;
               end
            end else if (bytes_sent_ff < 7'(LIMIT_GENERIC)) begin
               push_desc.mask[SLOT_SET] = 1'b1;
               push_desc.body[SLOT_SET[1:0]] = {1'b0, req.char_code[6:0]};
               bs = bs + 7'd1;
            end
            chars_left_in = chars_left_ff - 8'd1;
            finish = (chars_left_ff == 8'd1);
         end
         if (finish) begin
            if (mode_cmd || bs < 7'(LIMIT_GENERIC)) begin
               push_desc.mask[SLOT_CR] = 1'b1;
               push_desc.mask[SLOT_LF] = 1'b1;
            end else begin
               push_desc.mask[SLOT_CR] = 1'b1;
               push_desc.bare = 1'b1;
            end
            line_open_in    = 1'b0;
            chars_left_in   = 8'd0;
            eight_bit_on_in = 1'b0;
         end
         bytes_sent_in = bs;
      end
      push = accept && (push_desc.mask != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chars_left_ff   <= '0;
         bytes_sent_ff   <= '0;
         eight_bit_on_ff <= 1'b0;
         line_open_ff    <= 1'b0;
      end else begin
         chars_left_ff   <= chars_left_in;
         bytes_sent_ff   <= bytes_sent_in;
         eight_bit_on_ff <= eight_bit_on_in;
         line_open_ff    <= line_open_in;
      end
   end

endmodule

@@ hdl/pltf_queue.sv @@
module pltf_queue #(
   parameter int DEPTH = pltf_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pltf_pkg::pltf_desc_type  push_desc,
   input  logic                     pop,
   output pltf_pkg::pltf_desc_type  head_desc,
   output pltf_pkg::pltf_qstat_type qstat
);
   import pltf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pltf_desc_type    mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_desc   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hdl/pltf_back.sv @@
module pltf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pltf_pkg::pltf_desc_type  head_desc,
   input  pltf_pkg::pltf_qstat_type qstat,
   output logic                     pop,
   pltf_rsp_if.source               rsp
);
   import pltf_pkg::*;

   pltf_desc_type    cur_ff, cur_in;
   logic [SLOTS-1:0] mask_ff, mask_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             present_ff, present_in;
   logic             end_ff, end_in;

   logic             out_free;
   logic             have;
   logic             emit;
   logic [2:0]       slot;
   logic [SLOTS-1:0] rem;

   assign out_free = !valid_ff || rsp.ready;
   assign have     = (mask_ff != '0);
   assign emit     = have && out_free;

   // lowest pending slot goes out first
   always_comb begin
      slot = SLOT_ESC;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            slot = 3'(i);
         end
      end
   end

   assign rem = mask_ff & ~(SLOTS'(1) << slot);
   assign pop = !qstat.empty && (!have || (emit && rem == '0));

   always_comb begin
      cur_in     = cur_ff;
      mask_in    = mask_ff;
      valid_in   = valid_ff && !rsp.ready;
      byte_in    = byte_ff;
      present_in = present_ff;
      end_in     = end_ff;
      if (emit) begin
         valid_in = 1'b1;
         mask_in  = rem;
         case (slot)
            SLOT_CR: begin
               byte_in    = cur_ff.bare ? BYTE_NONE : BYTE_CR;
               present_in = !cur_ff.bare;
               end_in     = cur_ff.bare;
            end
            SLOT_LF: begin
               byte_in    = BYTE_LF;
               present_in = 1'b1;
               end_in     = 1'b1;
            end
            default: begin
               byte_in    = cur_ff.body[slot[1:0]];
               present_in = 1'b1;
               end_in     = 1'b0;
            end
         endcase
      end
      if (pop) begin
         cur_in  = head_desc;
         mask_in = head_desc.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      byte_ff    <= byte_in;
      present_ff <= present_in;
      end_ff     <= end_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.out_byte     = byte_ff;
   assign rsp.byte_present = present_ff;
   assign rsp.line_end     = end_ff;

endmodule

@@ hdl/printer_line_text_formatter.sv @@
// the first result of an item goes through the item queue, the current-item register and
//   the output register; throughput: one req transfer per cycle while the item queue has room;
//   results leave at one per cycle while rsp is ready, through the single output register,
//   and a header makes up to 6 results
// reset: synchronous, active high; clears line state, queue and output valid, and sets
//   the mode register to the command set
`include "printer_line_text_formatter_macros.svh"

module printer_line_text_formatter #(
   parameter int MAX_LINE      = pltf_pkg::DEF_MAX_LINE,
   parameter int LIMIT_CMD     = pltf_pkg::DEF_LIMIT_CMD,
   parameter int LIMIT_GENERIC = pltf_pkg::DEF_LIMIT_GENERIC,
   parameter int QUEUE_DEPTH   = pltf_pkg::DEF_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   pltf_req_if.sink    req_chan,
   pltf_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import pltf_pkg::*;

   logic           mode_ff, mode_in;
   logic           csr_wr;
   logic           mode_wr;
   logic           rsp_bare;
   logic           q_push;
   logic           q_pop;
   pltf_desc_type  q_push_desc;
   pltf_desc_type  q_head_desc;
   pltf_qstat_type q_stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign mode_wr    = csr_wr && (csr_paddr[2] == CSR_IDX_MODE);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MODE) ? {31'b0, mode_ff} : '0;
   assign rsp_bare   = rsp_chan.valid && !rsp_chan.byte_present;

   always_comb begin
      mode_in = mode_ff;
      if (mode_wr) begin
         mode_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
      end else begin
         mode_ff <= mode_in;
      end
   end

   pltf_front #(
      .MAX_LINE      (MAX_LINE),
      .LIMIT_CMD     (LIMIT_CMD),
      .LIMIT_GENERIC (LIMIT_GENERIC)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .mode_cmd  (mode_ff),
      .qstat     (q_stat),
      .push      (q_push),
      .push_desc (q_push_desc)
   );

   pltf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .pop       (q_pop),
      .head_desc (q_head_desc),
      .qstat     (q_stat)
   );

   pltf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_desc (q_head_desc),
      .qstat     (q_stat),
      .pop       (q_pop),
      .rsp       (rsp_chan)
   );

   `PLTF_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full)
   `PLTF_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty)
   `PLTF_ASSERT_NEXT(a_mode_write, mode_wr, mode_ff == $past(csr_pwdata[0]))
   `PLTF_ASSERT_NOW(a_bare_marker, rsp_bare, rsp_chan.line_end && rsp_chan.out_byte == BYTE_NONE)

endmodule
